// ===== rtl/smax_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smax_pkg
// Shared types and constants for the moving average crossover detector.
// ----------------------------------------------------------------------------
package smax_pkg;

   // Defaults for the top level parameters
   localparam int MAX_WINDOW_DEFAULT = 256;
   localparam int PRICE_BITS_DEFAULT = 32;
   localparam int OUT_DEPTH_DEFAULT  = 8;

   // Fixed field widths
   localparam int LEN_BITS       = 9;
   localparam int CLOSE_BITS     = 32;
   localparam int TIME_BITS      = 63;
   localparam int KIND_BITS      = 2;
   localparam int CSR_INDEX_BITS = 4;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORT_LENGTH = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_LENGTH  = 4'd1;

   // Register reset values
   localparam logic [LEN_BITS-1:0] SHORT_LENGTH_RESET = 9'd10;
   localparam logic [LEN_BITS-1:0] LONG_LENGTH_RESET  = 9'd50;

   // Result codes
   localparam logic [KIND_BITS-1:0] KIND_NONE = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_RISE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_FALL = 2'd2;

   // Relation of short average to long average
   typedef enum logic [1:0] {
      REL_BELOW = 2'd0,
      REL_EQUAL = 2'd1,
      REL_ABOVE = 2'd2
   } relation_type;

   typedef struct packed {
      logic [CLOSE_BITS-1:0] close_price;
      logic [TIME_BITS-1:0]  bar_time;
   } req_payload_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] signal_kind;
      logic [TIME_BITS-1:0] signal_time;
   } rsp_payload_type;

   // Per-transaction control carried down the pipeline
   typedef struct packed {
      logic rel_en;  // window full: compute relation
      logic sig_en;  // one bar past full: crossover may be reported
   } stage_ctrl_type;

endpackage

// ===== rtl/smax_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smax_window
// Price ring memory with two registered read ports and one write port, and
// the running short and long window sums.
// ----------------------------------------------------------------------------
module smax_window #(
   parameter int  MAX_WINDOW = smax_pkg::MAX_WINDOW_DEFAULT,
   parameter int  PRICE_BITS = smax_pkg::PRICE_BITS_DEFAULT,
   localparam int ADDR_W     = $clog2(MAX_WINDOW),
   localparam int LEN_W      = $clog2(MAX_WINDOW + 1),
   localparam int SUM_W      = PRICE_BITS + $clog2(MAX_WINDOW)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic                          push,
   input  logic [PRICE_BITS-1:0]         push_price,
   input  logic [smax_pkg::TIME_BITS-1:0] push_time,
   input  logic [LEN_W-1:0]              short_len,
   input  logic [LEN_W-1:0]              long_len,
   output logic                          sum_valid,
   output logic [SUM_W-1:0]              fast_total,
   output logic [SUM_W-1:0]              slow_total,
   output smax_pkg::stage_ctrl_type      sum_ctrl,
   output logic [smax_pkg::TIME_BITS-1:0] sum_time
);

   localparam int BARS_W = $clog2(MAX_WINDOW + 2);
   localparam int BACK_W = LEN_W + 1;
   localparam logic [BARS_W-1:0] BARS_CAP = BARS_W'(MAX_WINDOW + 1);
   localparam logic [ADDR_W-1:0] HEAD_LAST = ADDR_W'(MAX_WINDOW - 1);

   // Slot holding the price written n bars before the slot at head
   function automatic logic [ADDR_W-1:0] ring_back(input logic [ADDR_W-1:0] head,
                                                    input logic [LEN_W-1:0]  n);
      logic [BACK_W-1:0] hx;
      logic [BACK_W-1:0] nx;
      hx = BACK_W'(head);
      nx = BACK_W'(n);
      if (nx == BACK_W'(MAX_WINDOW)) begin
         return head;
      end else if (hx >= nx) begin
         return ADDR_W'(hx - nx);
      end else begin
         return ADDR_W'(hx + BACK_W'(MAX_WINDOW) - nx);
      end
   endfunction

   logic [PRICE_BITS-1:0] ring_mem [MAX_WINDOW];

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [BARS_W-1:0] bars_ff, bars_in;
   logic [ADDR_W-1:0] rd_short_addr, rd_long_addr;

   logic                           s1_valid_ff;
   logic [PRICE_BITS-1:0]          s1_price_ff;
   logic [PRICE_BITS-1:0]          s1_old_short_ff;
   logic [PRICE_BITS-1:0]          s1_old_long_ff;
   logic                           s1_sub_short_ff;
   logic                           s1_sub_long_ff;
   smax_pkg::stage_ctrl_type       s1_ctrl_ff;
   logic [smax_pkg::TIME_BITS-1:0] s1_time_ff;

   logic                           s2_valid_ff;
   logic [SUM_W-1:0]               fast_total_ff, fast_total_in;
   logic [SUM_W-1:0]               slow_total_ff, slow_total_in;
   smax_pkg::stage_ctrl_type       s2_ctrl_ff;
   logic [smax_pkg::TIME_BITS-1:0] s2_time_ff;

   // Address the oldest prices of each window and advance the head and count
   always_comb begin
      rd_short_addr = ring_back(head_ff, short_len);
      rd_long_addr  = ring_back(head_ff, long_len);
      head_in       = (head_ff == HEAD_LAST) ? '0 : head_ff + 1'b1;
      bars_in       = (bars_ff < BARS_CAP) ? bars_ff + 1'b1 : bars_ff;
   end

   // Write the new price and read the two leaving prices in the same cycle.
   // A full-depth window reads the slot being written and gets the old price.
   always_ff @(posedge clock) begin
      if (push) begin
         ring_mem[head_ff] <= push_price;
         s1_old_short_ff   <= ring_mem[rd_short_addr];
         s1_old_long_ff    <= ring_mem[rd_long_addr];
      end
   end

   // Ring head and bar count
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         head_ff <= '0;
         bars_ff <= '0;
      end else if (push) begin
         head_ff <= head_in;
         bars_ff <= bars_in;
      end
   end

   // Capture the transaction alongside the memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         s1_price_ff       <= push_price;
         s1_time_ff        <= push_time;
         s1_sub_short_ff   <= bars_ff >= BARS_W'(short_len);
         s1_sub_long_ff    <= bars_ff >= BARS_W'(long_len);
         s1_ctrl_ff.rel_en <= bars_in >= BARS_W'(long_len);
         s1_ctrl_ff.sig_en <= bars_in >= (BARS_W'(long_len) + 1'b1);
      end
   end

   // Drop the leaving price and add the new one
   always_comb begin
      fast_total_in = fast_total_ff + SUM_W'(s1_price_ff)
                    - (s1_sub_short_ff ? SUM_W'(s1_old_short_ff) : '0);
      slow_total_in = slow_total_ff + SUM_W'(s1_price_ff)
                    - (s1_sub_long_ff ? SUM_W'(s1_old_long_ff) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         fast_total_ff <= '0;
         slow_total_ff <= '0;
      end else if (s1_valid_ff) begin
         fast_total_ff <= fast_total_in;
         slow_total_ff <= slow_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_ctrl_ff <= s1_ctrl_ff;
         s2_time_ff <= s1_time_ff;
      end
   end

   assign sum_valid  = s2_valid_ff;
   assign fast_total = fast_total_ff;
   assign slow_total = slow_total_ff;
   assign sum_ctrl   = s2_ctrl_ff;
   assign sum_time   = s2_time_ff;

endmodule

// ===== rtl/smax_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smax_out_queue
// Result queue that decouples the free-running pipeline from rsp_stall.
// ----------------------------------------------------------------------------
module smax_out_queue #(
   parameter int DEPTH = smax_pkg::OUT_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  smax_pkg::rsp_payload_type push_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output smax_pkg::rsp_payload_type rsp_payload
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   smax_pkg::rsp_payload_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;

   // Advance pointers with explicit wrap
   always_comb begin
      wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/moving_average_crossover_detector.sv =====
`timescale 1ns / 1ps
// Path: an accepted transaction is registered with the ring read, then into the running sums,
// then into the products, and is then written into the output queue, which raises rsp_valid.
// Throughput: one transaction per cycle, set by the ring memory (one write and two reads a
// cycle) and the running sum update; input stalls only once OUT_DEPTH (8 by default) are outstanding.
// Reset: synchronous; clears control and sums and restores the lengths to 10 and 50. No
// clearing pass: a ring slot that the current run has not written is never used in a sum.
// ----------------------------------------------------------------------------
// moving_average_crossover_detector
// Simple moving average crossover on a stream of closing prices, compared
// exactly by cross-multiplication.
// ----------------------------------------------------------------------------
module moving_average_crossover_detector #(
   parameter int MAX_WINDOW = smax_pkg::MAX_WINDOW_DEFAULT,
   parameter int PRICE_BITS = smax_pkg::PRICE_BITS_DEFAULT,
   parameter int OUT_DEPTH  = smax_pkg::OUT_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  smax_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output smax_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [smax_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [smax_pkg::LEN_BITS-1:0]       csr_wdata
);

   localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = PRICE_BITS + $clog2(MAX_WINDOW);
   localparam int PROD_W = SUM_W + LEN_W;
   localparam int OCC_W  = $clog2(OUT_DEPTH + 1);

   // Zero reads as one, oversized reads as the ring depth
   function automatic logic [LEN_W-1:0] eff_len(input logic [smax_pkg::LEN_BITS-1:0] r);
      if (r == '0) begin
         return LEN_W'(1);
      end else if (int'(r) > MAX_WINDOW) begin
         return LEN_W'(MAX_WINDOW);
      end else begin
         return LEN_W'(r);
      end
   endfunction

   logic [smax_pkg::LEN_BITS-1:0] short_length_ff;
   logic [smax_pkg::LEN_BITS-1:0] long_length_ff;
   logic                          csr_fire;
   logic                          restart;

   logic [LEN_W-1:0] long_len;
   logic [LEN_W-1:0] short_eff;
   logic [LEN_W-1:0] short_len;

   logic                           req_fire;
   logic                           rsp_fire;
   logic [OCC_W-1:0]               occ_ff, occ_in;

   logic                           sum_valid;
   logic [SUM_W-1:0]               fast_total;
   logic [SUM_W-1:0]               slow_total;
   smax_pkg::stage_ctrl_type       sum_ctrl;
   logic [smax_pkg::TIME_BITS-1:0] sum_time;

   logic                           s3_valid_ff;
   logic [PROD_W-1:0]              s3_short_prod_ff;
   logic [PROD_W-1:0]              s3_long_prod_ff;
   smax_pkg::stage_ctrl_type       s3_ctrl_ff;
   logic [smax_pkg::TIME_BITS-1:0] s3_time_ff;

   smax_pkg::relation_type         prior_ff;
   smax_pkg::relation_type         rel_now;
   smax_pkg::rsp_payload_type      result;

   // Configuration: always ready, restart the stream on any known register
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign restart   = csr_fire && ((csr_index == smax_pkg::CSR_SHORT_LENGTH) ||
                                   (csr_index == smax_pkg::CSR_LONG_LENGTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         short_length_ff <= smax_pkg::SHORT_LENGTH_RESET;
         long_length_ff  <= smax_pkg::LONG_LENGTH_RESET;
      end else if (csr_fire) begin
         unique case (csr_index)
            smax_pkg::CSR_SHORT_LENGTH: begin
               short_length_ff <= csr_wdata;
            end
            smax_pkg::CSR_LONG_LENGTH: begin
               long_length_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Effective window lengths; short is clamped to long
   always_comb begin
      long_len  = eff_len(long_length_ff);
      short_eff = eff_len(short_length_ff);
      short_len = (short_eff > long_len) ? long_len : short_eff;
   end

   // Count transactions in flight or queued; hold off input when the queue could fill
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign req_stall = (occ_ff >= OCC_W'(OUT_DEPTH));
   assign occ_in    = occ_ff + OCC_W'(req_fire) - OCC_W'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   smax_window #(
      .MAX_WINDOW (MAX_WINDOW),
      .PRICE_BITS (PRICE_BITS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .push       (req_fire),
      .push_price (PRICE_BITS'(req_payload.close_price)),
      .push_time  (req_payload.bar_time),
      .short_len  (short_len),
      .long_len   (long_len),
      .sum_valid  (sum_valid),
      .fast_total (fast_total),
      .slow_total (slow_total),
      .sum_ctrl   (sum_ctrl),
      .sum_time   (sum_time)
   );

   // Cross-multiply the sums by the opposite window length
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= sum_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_valid) begin
         s3_short_prod_ff <= PROD_W'(fast_total) * PROD_W'(long_len);
         s3_long_prod_ff  <= PROD_W'(slow_total) * PROD_W'(short_len);
         s3_ctrl_ff       <= sum_ctrl;
         s3_time_ff       <= sum_time;
      end
   end

   // Compare the products and detect a change of side
   always_comb begin
      if (s3_short_prod_ff < s3_long_prod_ff) begin
         rel_now = smax_pkg::REL_BELOW;
      end else if (s3_short_prod_ff > s3_long_prod_ff) begin
         rel_now = smax_pkg::REL_ABOVE;
      end else begin
         rel_now = smax_pkg::REL_EQUAL;
      end

      result.signal_kind = smax_pkg::KIND_NONE;
      result.signal_time = s3_time_ff;
      if (s3_ctrl_ff.sig_en) begin
         if (prior_ff == smax_pkg::REL_BELOW && rel_now == smax_pkg::REL_ABOVE) begin
            result.signal_kind = smax_pkg::KIND_RISE;
         end else if (prior_ff == smax_pkg::REL_ABOVE && rel_now == smax_pkg::REL_BELOW) begin
            result.signal_kind = smax_pkg::KIND_FALL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         prior_ff <= smax_pkg::REL_EQUAL;
      end else if (s3_valid_ff && s3_ctrl_ff.rel_en) begin
         prior_ff <= rel_now;
      end
   end

   smax_out_queue #(
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (s3_valid_ff),
      .push_data   (result),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
